// ===== rtl/core/plcu_pkg.sv =====
// ----------------------------------------------------------------------------
// plcu_pkg
// Shared types and constants of the piecewise-linear curve unit.
// ----------------------------------------------------------------------------
package plcu_pkg;

   localparam int POINTS = 32;
   localparam int IDX_W  = $clog2(POINTS);
   localparam int CNT_W  = 6;
   localparam logic [CNT_W-1:0] POINTS_CNT = CNT_W'(POINTS);

   localparam int MUL_STEPS = 32;
   localparam int DIV_STEPS = 48;

   localparam logic [1:0] OP_APPEND_A = 2'd0;
   localparam logic [1:0] OP_APPEND_B = 2'd1;
   localparam logic [1:0] OP_EVAL     = 2'd2;
   localparam logic [1:0] OP_ADD      = 2'd3;

   localparam logic [2:0] STAT_OK     = 3'd0;
   localparam logic [2:0] STAT_PAST   = 3'd1;
   localparam logic [2:0] STAT_FULL   = 3'd2;
   localparam logic [2:0] STAT_ORDER  = 3'd3;
   localparam logic [2:0] STAT_ORIGIN = 3'd4;
   localparam logic [2:0] STAT_LONG   = 3'd5;

   localparam logic signed [47:0] Y_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] Y_MIN = 48'sh8000_0000_0000;

   typedef struct packed {
      logic [1:0]         op;
      logic               restart;
      logic [31:0]        pos_x;
      logic signed [47:0] pos_y;
   } req_type;

   typedef struct packed {
      logic signed [47:0] value;
      logic [2:0]         status;
      logic [CNT_W-1:0]   count;
   } rsp_type;

   typedef struct packed {
      logic [31:0]        x;
      logic signed [47:0] y;
   } point_type;

   typedef struct packed {
      logic        start;
      logic [31:0] t;
      logic [31:0] den;
      logic [47:0] mag;
   } md_req_type;

   typedef struct packed {
      logic        done;
      logic [47:0] q;
   } md_rsp_type;

endpackage

// ===== rtl/core/plcu_muldiv.sv =====
// ----------------------------------------------------------------------------
// plcu_muldiv
// Serial floor(t * mag / den): shift-add multiply, then restoring divide.
// ----------------------------------------------------------------------------
module plcu_muldiv (
   input  logic                clock,
   input  logic                reset,
   input  plcu_pkg::md_req_type md_req,
   output plcu_pkg::md_rsp_type md_rsp
);
   import plcu_pkg::*;

   logic        busy_ff, busy_in;
   logic        div_ff, div_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [79:0] acc_ff, acc_in;
   logic [31:0] t_ff, t_in;
   logic [31:0] den_ff, den_in;
   logic [47:0] mag_ff, mag_in;
   logic [32:0] r2;
   logic        ge;
   logic [32:0] r2_sub;

   assign r2     = {acc_ff[79:48], acc_ff[47]};
   assign ge     = r2 >= {1'b0, den_ff};
   assign r2_sub = r2 - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      t_in    = t_ff;
      den_in  = den_ff;
      mag_in  = mag_ff;
      if (md_req.start) begin
         busy_in = 1'b1;
         div_in  = 1'b0;
         cnt_in  = '0;
         acc_in  = '0;
         t_in    = md_req.t;
         den_in  = md_req.den;
         mag_in  = md_req.mag;
      end else if (busy_ff && !div_ff) begin
         acc_in = {acc_ff[78:0], 1'b0} + (t_ff[31] ? {32'd0, mag_ff} : 80'd0);
         t_in   = {t_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(MUL_STEPS - 1)) begin
            div_in = 1'b1;
            cnt_in = '0;
         end
      end else if (busy_ff) begin
         acc_in = {(ge ? r2_sub[31:0] : r2[31:0]), acc_ff[46:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         div_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         div_ff  <= div_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      t_ff   <= t_in;
      den_ff <= den_in;
      mag_ff <= mag_in;
   end

   assign md_rsp.done = done_ff;
   assign md_rsp.q    = acc_ff[47:0];

   assert property (@(posedge clock) disable iff (reset)
      md_req.start |=> busy_ff && !div_ff)
      else $error("muldiv did not start");
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("muldiv done while busy");
   assert property (@(posedge clock) disable iff (reset)
      busy_ff && div_ff |-> acc_ff[79:48] < den_ff)
      else $error("muldiv remainder not below divisor");

endmodule

// ===== rtl/core/plcu_seq.sv =====
// ----------------------------------------------------------------------------
// plcu_seq
// Curve storage and sequencer for append, evaluate and merge-add.
// ----------------------------------------------------------------------------
module plcu_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  plcu_pkg::req_type req,
   output logic              idle,
   output logic              done,
   output plcu_pkg::rsp_type rsp,
   input  logic              ack
);
   import plcu_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_AP_RD   = 4'd1;
   localparam logic [3:0] S_AP_CHK  = 4'd2;
   localparam logic [3:0] S_EV_RD   = 4'd3;
   localparam logic [3:0] S_EV_CMP  = 4'd4;
   localparam logic [3:0] S_EV_DIV  = 4'd5;
   localparam logic [3:0] S_EV_END  = 4'd6;
   localparam logic [3:0] S_AD_RD   = 4'd7;
   localparam logic [3:0] S_AD_CHK  = 4'd8;
   localparam logic [3:0] S_MG_RD   = 4'd9;
   localparam logic [3:0] S_MG_SEL  = 4'd10;
   localparam logic [3:0] S_MG_WR   = 4'd11;
   localparam logic [3:0] S_CP_RD   = 4'd12;
   localparam logic [3:0] S_CP_WR   = 4'd13;
   localparam logic [3:0] S_DONE    = 4'd14;

   point_type a_mem [POINTS];
   point_type b_mem [POINTS];
   point_type m_mem [POINTS];
   point_type a_rd_ff, b_rd_ff, m_rd_ff;
   logic [IDX_W-1:0] a_raddr, b_raddr, m_raddr, a_waddr, b_waddr, m_waddr;
   logic a_we, b_we, m_we;
   point_type a_wdata, m_wdata;

   logic [3:0]       state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   logic             restart_ff, restart_in;
   point_type        pt_ff, pt_in;
   logic [CNT_W-1:0] a_cnt_ff, a_cnt_in, b_cnt_ff, b_cnt_in;
   logic [CNT_W-1:0] idx_ff, idx_in, i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic             sel_ff, sel_in;
   logic [31:0]      ex_ff, ex_in;
   point_type        prev_ff, prev_in, cur_ff, cur_in;
   logic [47:0]      res_ff, res_in;
   logic             ok_ff, ok_in, neg_ff, neg_in, fa_ff, fa_in;
   logic [31:0]      last_x_ff, last_x_in;
   logic [2:0]       status_ff, status_in;
   logic [47:0]      value_ff, value_in;

   md_req_type       md_req;
   md_rsp_type       md_rsp;

   logic [CNT_W-1:0] ap_cnt;
   point_type        ev_pt, mg_pt;
   logic [CNT_W-1:0] ev_n;
   logic [48:0]      dy, dy_neg;
   logic             from_a;
   logic [48:0]      sum;
   logic [47:0]      sum_sat;
   logic [CNT_W:0]   tot;

   plcu_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   always_ff @(posedge clock) begin
      a_rd_ff <= a_mem[a_raddr];
      b_rd_ff <= b_mem[b_raddr];
      m_rd_ff <= m_mem[m_raddr];
      if (a_we) a_mem[a_waddr] <= a_wdata;
      if (b_we) b_mem[b_waddr] <= pt_ff;
      if (m_we) m_mem[m_waddr] <= m_wdata;
   end

   assign ap_cnt = restart_ff ? '0 : ((op_ff == OP_APPEND_B) ? b_cnt_ff : a_cnt_ff);
   assign ev_pt  = sel_ff ? b_rd_ff : a_rd_ff;
   assign ev_n   = sel_ff ? b_cnt_ff : a_cnt_ff;
   assign dy     = {ev_pt.y[47], ev_pt.y} - {prev_ff.y[47], prev_ff.y};
   assign dy_neg = -dy;
   assign from_a = (j_ff >= b_cnt_ff) || ((i_ff < a_cnt_ff) && (a_rd_ff.x <= b_rd_ff.x));
   assign mg_pt  = from_a ? a_rd_ff : b_rd_ff;
   assign sum    = {cur_ff.y[47], cur_ff.y} + {res_ff[47], res_ff};
   assign sum_sat = (sum[48] != sum[47]) ? (sum[48] ? Y_MIN : Y_MAX) : sum[47:0];
   assign tot    = {1'b0, a_cnt_ff} + {1'b0, b_cnt_ff};

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      restart_in = restart_ff;
      pt_in      = pt_ff;
      a_cnt_in   = a_cnt_ff;
      b_cnt_in   = b_cnt_ff;
      idx_in     = idx_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      sel_in     = sel_ff;
      ex_in      = ex_ff;
      prev_in    = prev_ff;
      cur_in     = cur_ff;
      res_in     = res_ff;
      ok_in      = ok_ff;
      neg_in     = neg_ff;
      fa_in      = fa_ff;
      last_x_in  = last_x_ff;
      status_in  = status_ff;
      value_in   = value_ff;
      a_raddr    = '0;
      b_raddr    = '0;
      m_raddr    = '0;
      a_we       = 1'b0;
      b_we       = 1'b0;
      m_we       = 1'b0;
      a_waddr    = ap_cnt[IDX_W-1:0];
      b_waddr    = ap_cnt[IDX_W-1:0];
      m_waddr    = k_ff[IDX_W-1:0];
      a_wdata    = pt_ff;
      m_wdata    = cur_ff;
      md_req.start = 1'b0;
      md_req.t     = ex_ff - prev_ff.x;
      md_req.den   = ev_pt.x - prev_ff.x;
      md_req.mag   = dy[48] ? dy_neg[47:0] : dy[47:0];
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in      = req.op;
               restart_in = req.restart;
               pt_in.x    = req.pos_x;
               pt_in.y    = req.pos_y;
               value_in   = '0;
               status_in  = STAT_OK;
               unique case (req.op)
                  OP_APPEND_A, OP_APPEND_B: state_in = S_AP_RD;
                  OP_EVAL: begin
                     sel_in   = 1'b0;
                     ex_in    = req.pos_x;
                     idx_in   = '0;
                     state_in = S_EV_RD;
                  end
                  default: state_in = S_AD_RD;
               endcase
            end
         end
         S_AP_RD: begin
            a_raddr = IDX_W'(ap_cnt - 6'd1);
            b_raddr = IDX_W'(ap_cnt - 6'd1);
            if (ap_cnt >= POINTS_CNT) begin
               status_in = STAT_FULL;
               state_in  = S_DONE;
            end else if (ap_cnt == '0) begin
               if (op_ff == OP_APPEND_B) begin
                  b_we     = 1'b1;
                  b_cnt_in = 6'd1;
               end else begin
                  a_we     = 1'b1;
                  a_cnt_in = 6'd1;
               end
               state_in = S_DONE;
            end else begin
               state_in = S_AP_CHK;
            end
         end
         S_AP_CHK: begin
            if (pt_ff.x < ((op_ff == OP_APPEND_B) ? b_rd_ff.x : a_rd_ff.x)) begin
               status_in = STAT_ORDER;
            end else if (op_ff == OP_APPEND_B) begin
               b_we     = 1'b1;
               b_cnt_in = ap_cnt + 6'd1;
            end else begin
               a_we     = 1'b1;
               a_cnt_in = ap_cnt + 6'd1;
            end
            state_in = S_DONE;
         end
         S_EV_RD: begin
            a_raddr = idx_ff[IDX_W-1:0];
            b_raddr = idx_ff[IDX_W-1:0];
            if (idx_ff >= ev_n) begin
               ok_in    = 1'b0;
               state_in = S_EV_END;
            end else begin
               state_in = S_EV_CMP;
            end
         end
         S_EV_CMP: begin
            ok_in = 1'b1;
            if (ev_pt.x < ex_ff) begin
               prev_in  = ev_pt;
               idx_in   = idx_ff + 6'd1;
               state_in = S_EV_RD;
            end else if (ev_pt.x == ex_ff) begin
               res_in   = ev_pt.y;
               state_in = S_EV_END;
            end else if (idx_ff == '0) begin
               res_in   = '0;
               state_in = S_EV_END;
            end else begin
               md_req.start = 1'b1;
               neg_in       = dy[48];
               state_in     = S_EV_DIV;
            end
         end
         S_EV_DIV: begin
            if (md_rsp.done) begin
               res_in   = neg_ff ? (prev_ff.y - md_rsp.q) : (prev_ff.y + md_rsp.q);
               state_in = S_EV_END;
            end
         end
         S_EV_END: begin
            if (!ok_ff) begin
               status_in = STAT_PAST;
               state_in  = S_DONE;
            end else if (op_ff == OP_EVAL) begin
               value_in = res_ff;
               state_in = S_DONE;
            end else begin
               cur_in.y = sum_sat;
               state_in = S_MG_WR;
            end
         end
         S_AD_RD: begin
            a_raddr = '0;
            b_raddr = '0;
            if (a_cnt_ff == '0 || b_cnt_ff == '0) begin
               status_in = STAT_ORIGIN;
               state_in  = S_DONE;
            end else begin
               state_in = S_AD_CHK;
            end
         end
         S_AD_CHK: begin
            if (a_rd_ff.x != '0 || a_rd_ff.y != '0 || b_rd_ff.x != '0 || b_rd_ff.y != '0) begin
               status_in = STAT_ORIGIN;
               state_in  = S_DONE;
            end else if (tot > {1'b0, POINTS_CNT}) begin
               status_in = STAT_LONG;
               state_in  = S_DONE;
            end else begin
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               state_in = S_MG_RD;
            end
         end
         S_MG_RD: begin
            a_raddr = i_ff[IDX_W-1:0];
            b_raddr = j_ff[IDX_W-1:0];
            if (i_ff >= a_cnt_ff && j_ff >= b_cnt_ff) begin
               idx_in   = '0;
               state_in = S_CP_RD;
            end else begin
               state_in = S_MG_SEL;
            end
         end
         S_MG_SEL: begin
            fa_in  = from_a;
            cur_in = mg_pt;
            if (k_ff == '0 || last_x_ff != mg_pt.x) begin
               sel_in   = from_a;
               ex_in    = mg_pt.x;
               idx_in   = '0;
               state_in = S_EV_RD;
            end else begin
               state_in = S_MG_WR;
            end
         end
         S_MG_WR: begin
            m_we      = 1'b1;
            last_x_in = cur_ff.x;
            k_in      = k_ff + 6'd1;
            if (fa_ff) i_in = i_ff + 6'd1;
            else       j_in = j_ff + 6'd1;
            state_in  = S_MG_RD;
         end
         S_CP_RD: begin
            m_raddr = idx_ff[IDX_W-1:0];
            if (idx_ff >= k_ff) begin
               a_cnt_in = k_ff;
               state_in = S_DONE;
            end else begin
               state_in = S_CP_WR;
            end
         end
         S_CP_WR: begin
            a_we     = 1'b1;
            a_waddr  = idx_ff[IDX_W-1:0];
            a_wdata  = m_rd_ff;
            idx_in   = idx_ff + 6'd1;
            state_in = S_CP_RD;
         end
         S_DONE: begin
            if (ack) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         a_cnt_ff <= '0;
         b_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         a_cnt_ff <= a_cnt_in;
         b_cnt_ff <= b_cnt_in;
      end
      op_ff      <= op_in;
      restart_ff <= restart_in;
      pt_ff      <= pt_in;
      idx_ff     <= idx_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      k_ff       <= k_in;
      sel_ff     <= sel_in;
      ex_ff      <= ex_in;
      prev_ff    <= prev_in;
      cur_ff     <= cur_in;
      res_ff     <= res_in;
      ok_ff      <= ok_in;
      neg_ff     <= neg_in;
      fa_ff      <= fa_in;
      last_x_ff  <= last_x_in;
      status_ff  <= status_in;
      value_ff   <= value_in;
   end

   assign idle       = (state_ff == S_IDLE);
   assign done       = (state_ff == S_DONE);
   assign rsp.value  = value_ff;
   assign rsp.status = status_ff;
   assign rsp.count  = a_cnt_ff;

   assert property (@(posedge clock) disable iff (reset)
      a_cnt_ff <= POINTS_CNT && b_cnt_ff <= POINTS_CNT)
      else $error("curve count beyond capacity");
   assert property (@(posedge clock) disable iff (reset)
      md_rsp.done |-> state_ff == S_EV_DIV)
      else $error("divide result with no waiting evaluation");
   assert property (@(posedge clock) disable iff (reset)
      done |-> status_ff <= STAT_LONG)
      else $error("bad status code");
   assert property (@(posedge clock) disable iff (reset)
      done && status_ff != STAT_OK |-> value_ff == '0)
      else $error("nonzero value with error status");

endmodule

// ===== rtl/core/piecewise_linear_curve_unit_core.sv =====
// Evaluate scans the curve point by point and, when interpolating, runs the serial
//   multiply (32 steps) and then the divide (48 steps).
// Add merges both curves, evaluating the other at each new x, then copies the merge into A.
// One item in flight; the shared multiply-divide unit and the curve read ports set the rate.
// A result register lets the next transfer in while a result waits.
// Synchronous reset empties both curves; stored points are not cleared.
// ----------------------------------------------------------------------------
// piecewise_linear_curve_unit_core
// Two piecewise-linear curves with append, evaluate and add operations.
// ----------------------------------------------------------------------------
module piecewise_linear_curve_unit_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  plcu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output plcu_pkg::rsp_type rsp_data
);
   import plcu_pkg::*;

   logic    seq_idle, seq_done, seq_ack;
   rsp_type seq_rsp;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   plcu_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (req_valid && req_ready),
      .req   (req_data),
      .idle  (seq_idle),
      .done  (seq_done),
      .rsp   (seq_rsp),
      .ack   (seq_ack)
   );

   assign req_ready = seq_idle;
   assign seq_ack   = seq_done && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (seq_ack) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result transfer dropped");
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      seq_ack |=> rsp_valid)
      else $error("result lost");

endmodule

// ===== tb/piecewise_linear_curve_unit_core_tb.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_curve_unit_core_tb
// Drives append, evaluate and add transfers into the curve unit, predicts each
// result with an in-bench curve model and compares every field in order.
// ----------------------------------------------------------------------------
module piecewise_linear_curve_unit_core_tb;
   import plcu_pkg::*;

   localparam int LIMIT = 20000000;

   typedef struct packed {
      logic        chk;
      req_type     req;
      rsp_type     rsp;
   } row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   logic [31:0]        ax [POINTS];
   logic signed [47:0] ay [POINTS];
   int                 acnt;
   logic [31:0]        bx [POINTS];
   logic signed [47:0] by [POINTS];
   int                 bcnt;

   rsp_type pending_rsp[$];
   row_type table_rows[$];
   int      errors;
   int      cycles;
   int      send_idle;
   int      recv_idle;

   piecewise_linear_curve_unit_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic signed [47:0] sat48(logic signed [49:0] s);
      if (s > 50'sd140737488355327) return Y_MAX;
      if (s < -50'sd140737488355328) return Y_MIN;
      return s[47:0];
   endfunction

   function automatic bit curve_at(bit use_b, logic [31:0] x, output logic signed [47:0] r);
      int                 i;
      int                 n;
      logic [31:0]        xi, xp;
      logic signed [47:0] yi, yp;
      logic signed [49:0] dy;
      logic [63:0]        mag, t, d, q;
      n = use_b ? bcnt : acnt;
      i = 0;
      while (i < n && (use_b ? bx[i] : ax[i]) < x) i++;
      if (i >= n) return 0;
      xi = use_b ? bx[i] : ax[i];
      yi = use_b ? by[i] : ay[i];
      if (xi == x) begin
         r = yi;
         return 1;
      end
      if (i == 0) begin
         r = '0;
         return 1;
      end
      xp = use_b ? bx[i-1] : ax[i-1];
      yp = use_b ? by[i-1] : ay[i-1];
      dy = 50'(yi) - 50'(yp);
      mag = dy < 0 ? 64'(-dy) : 64'(dy);
      t = 64'(x - xp);
      d = 64'(xi - xp);
      q = t * (mag / d) + (t * (mag % d)) / d;
      r = dy < 0 ? yp - 48'(q) : yp + 48'(q);
      return 1;
   endfunction

   function automatic logic [2:0] append_point(bit use_b, bit rs, logic [31:0] x,
                                               logic signed [47:0] y);
      int c;
      c = rs ? 0 : (use_b ? bcnt : acnt);
      if (c >= POINTS) return STAT_FULL;
      if (c > 0 && x < (use_b ? bx[c-1] : ax[c-1])) return STAT_ORDER;
      if (use_b) begin
         bx[c] = x; by[c] = y; bcnt = c + 1;
      end else begin
         ax[c] = x; ay[c] = y; acnt = c + 1;
      end
      return STAT_OK;
   endfunction

   function automatic logic [2:0] add_curves();
      int                 i, j, k;
      bit                 from_a;
      logic [31:0]        x;
      logic signed [47:0] y, other;
      logic [31:0]        mx [POINTS];
      logic signed [47:0] my [POINTS];
      if (acnt == 0 || bcnt == 0 || ax[0] != 0 || ay[0] != 0 || bx[0] != 0 || by[0] != 0)
         return STAT_ORIGIN;
      if (acnt + bcnt > POINTS) return STAT_LONG;
      i = 0; j = 0; k = 0;
      while (i < acnt || j < bcnt) begin
         from_a = j >= bcnt || (i < acnt && ax[i] <= bx[j]);
         x = from_a ? ax[i] : bx[j];
         y = from_a ? ay[i] : by[j];
         if (k == 0 || mx[k-1] != x) begin
            if (!curve_at(from_a, x, other)) return STAT_PAST;
            y = sat48(50'(y) + 50'(other));
         end
         mx[k] = x; my[k] = y;
         k++;
         if (from_a) i++; else j++;
      end
      for (int m = 0; m < k; m++) begin
         ax[m] = mx[m]; ay[m] = my[m];
      end
      acnt = k;
      return STAT_OK;
   endfunction

   function automatic rsp_type predict_curve(req_type r);
      rsp_type            o;
      logic signed [47:0] v;
      o = '0;
      case (r.op)
         OP_APPEND_A: o.status = append_point(0, r.restart, r.pos_x, r.pos_y);
         OP_APPEND_B: o.status = append_point(1, r.restart, r.pos_x, r.pos_y);
         OP_EVAL: begin
            if (curve_at(0, r.pos_x, v)) begin
               o.status = STAT_OK; o.value = v;
            end else o.status = STAT_PAST;
         end
         default: o.status = add_curves();
      endcase
      o.count = CNT_W'(acnt);
      return o;
   endfunction

   function automatic req_type mk(logic [1:0] op, bit rs, logic [31:0] x, logic signed [47:0] y);
      req_type r;
      r.op = op; r.restart = rs; r.pos_x = x; r.pos_y = y;
      return r;
   endfunction

   task automatic row(bit chk, req_type r, logic signed [47:0] v, logic [2:0] s, int c);
      row_type t;
      t.chk = chk; t.req = r; t.rsp.value = v; t.rsp.status = s; t.rsp.count = CNT_W'(c);
      table_rows.push_back(t);
   endtask

   task automatic send_item(req_type r);
      if (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsp.push_back(predict_curve(r));
   endtask

   function automatic req_type rand_req(int style);
      req_type r;
      int      p;
      r = mk(2'($urandom_range(3)), 1'($urandom_range(1)), $urandom,
             48'({$urandom, $urandom} >> 16));
      if (style == 0) begin
         p = $urandom_range(9);
         if (p < 4) begin
            r.op = 2'($urandom_range(1));
            r.restart = ($urandom_range(7) == 0);
            if (r.restart) begin
               r.pos_x = 0; r.pos_y = 0;
            end else begin
               r.pos_x = (r.op ? (bcnt ? bx[bcnt-1] : 0) : (acnt ? ax[acnt-1] : 0))
                         + $urandom_range(3) * $urandom_range(1000);
               if ($urandom_range(4) == 0) r.pos_y = $urandom_range(1) ? Y_MAX : Y_MIN;
               else if ($urandom_range(1)) r.pos_y = $signed(48'($urandom_range(2000))) - 1000;
            end
         end else if (p < 8) begin
            r.op = OP_EVAL;
            if (acnt > 0 && $urandom_range(3) != 0)
               r.pos_x = ax[acnt-1] - $urandom_range(ax[acnt-1] > 5000 ? 5000 : ax[acnt-1]);
         end else r.op = OP_ADD;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
      if (!reset) begin
         rsp_ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $error("unexpected transfer %p", rsp_data);
               errors++;
            end else begin
               rsp_type e;
               e = pending_rsp.pop_front();
               if (rsp_data.value !== e.value) begin
                  $error("value expected %0d actual %0d", e.value, rsp_data.value);
                  errors++;
               end
               if (rsp_data.status !== e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp_data.status);
                  errors++;
               end
               if (rsp_data.count !== e.count) begin
                  $error("count expected %0d actual %0d", e.count, rsp_data.count);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      row_type t;
      rsp_type p;
      errors = 0; cycles = 0; send_idle = 0; recv_idle = 0;
      reset = 1'b1; req_valid = 1'b0; req_data = '0; rsp_ready = 1'b0;
      acnt = 0; bcnt = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      row(1, mk(OP_EVAL, 0, 0, 0), 0, STAT_PAST, 0);
      row(1, mk(OP_ADD, 1, 0, 0), 0, STAT_ORIGIN, 0);
      row(1, mk(OP_APPEND_A, 0, 0, 0), 0, STAT_OK, 1);
      row(1, mk(OP_APPEND_A, 0, 100, 1000), 0, STAT_OK, 2);
      row(1, mk(OP_APPEND_A, 0, 50, 5), 0, STAT_ORDER, 2);
      row(1, mk(OP_APPEND_A, 0, 100, -7), 0, STAT_OK, 3);
      row(1, mk(OP_EVAL, 0, 100, 0), 1000, STAT_OK, 3);
      row(0, mk(OP_EVAL, 0, 33, 0), 0, 0, 0);
      row(1, mk(OP_EVAL, 0, 32'hFFFF_FFFF, 0), 0, STAT_PAST, 3);
      row(1, mk(OP_ADD, 0, 0, 0), 0, STAT_ORIGIN, 3);
      row(1, mk(OP_APPEND_B, 0, 0, 0), 0, STAT_OK, 3);
      row(1, mk(OP_APPEND_B, 0, 40, Y_MAX), 0, STAT_OK, 3);
      row(1, mk(OP_ADD, 0, 0, 0), 0, STAT_PAST, 3);
      row(1, mk(OP_APPEND_B, 0, 32'hFFFF_FFFF, Y_MIN), 0, STAT_OK, 3);
      row(0, mk(OP_ADD, 1, 0, 0), 0, 0, 0);
      row(0, mk(OP_EVAL, 0, 70, 0), 0, 0, 0);
      row(1, mk(OP_APPEND_A, 1, 5, Y_MIN), 0, STAT_OK, 1);
      row(1, mk(OP_EVAL, 0, 0, 0), 0, STAT_OK, 1);
      row(0, mk(OP_APPEND_A, 0, 32'hFFFF_FFFF, Y_MAX), 0, 0, 0);
      row(0, mk(OP_EVAL, 0, 32'h8000_0000, 0), 0, 0, 0);
      foreach (table_rows[i]) begin
         t = table_rows[i];
         send_item(t.req);
         if (t.chk) begin
            p = pending_rsp[pending_rsp.size()-1];
            if (p !== t.rsp) begin
               $error("table row %0d expected %p predicted %p", i, t.rsp, p);
               errors++;
            end
         end
      end
      repeat (40) send_item(mk(OP_APPEND_B, 0, 32'hFFFF_FFFF, 0));
      send_item(mk(OP_APPEND_B, 1, 0, 0));
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = ph == 0 ? 7 : (ph == 1 ? 70 : 0);
         recv_idle = ph == 0 ? 70 : (ph == 1 ? 7 : 0);
         for (int n = 0; n < 240; n++) begin
            if ($urandom_range(30) == 0) begin
               send_item(mk(OP_APPEND_A, 1, 0, 0));
               send_item(mk(OP_APPEND_B, 1, 0, 0));
            end
            send_item(rand_req($urandom_range(9) == 0));
         end
      end
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/core/plcu_pkg.sv
rtl/core/plcu_muldiv.sv
rtl/core/plcu_seq.sv
rtl/core/piecewise_linear_curve_unit_core.sv
tb/piecewise_linear_curve_unit_core_tb.sv
